/* rtl/alstat_pkg.sv */
// Shared types and constants for the audio level statistics block.
`default_nettype none
package alstat_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 64;
    localparam int MSUM_W    = 63;
    localparam int SQ_W      = 33;
    localparam int ENV_W     = 33;
    localparam int CNT_W     = 40;
    localparam int PREFIX_W  = 47;
    localparam int COEF_W    = 24;
    localparam int FRAC_W    = 16;
    localparam int TGT_W     = 56;
    localparam int DIVN_W    = 63;
    localparam int DIVD_W    = 62;
    localparam int DIVQ_W    = 23;
    localparam int STEP_W    = 5;
    localparam int SCALE_W   = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [STEP_W-1:0] DIV_FRAC_STEPS  = 5'd23;

    localparam logic [COEF_W-1:0] ATTACK_RESET   = 24'd16359;
    localparam logic [FRAC_W-1:0] FRACTION_RESET = 16'd65470;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 1'd1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic load_in;
        logic smp_a;
        logic smp_b;
        logic smp_wb;
        logic clr_step;
        logic rep_init;
        logic rep_read;
        logic rep_check;
        logic rep_next;
        logic div_exact;
        logic div_frac;
        logic div_scale;
        logic mag_zero;
        logic mag_take;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mode;
        logic ch_ok;
        logic hit_eq;
        logic hit_gt;
        logic last_bin;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/alstat_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module alstat_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [alstat_pkg::DIVN_W-1:0]    i_num,
    input  wire logic [alstat_pkg::DIVD_W-1:0]    i_dsh,
    input  wire logic [alstat_pkg::STEP_W-1:0]    i_steps,
    output logic                                  o_done,
    output logic [alstat_pkg::DIVQ_W-1:0]         o_quot
);
    logic [alstat_pkg::STEP_W-1:0] r_cnt;
    logic [alstat_pkg::DIVN_W-1:0] r_rem;
    logic [alstat_pkg::DIVD_W-1:0] r_dsh;
    logic [alstat_pkg::DIVQ_W-1:0] r_quot;
    logic                          ge;

    assign ge     = r_rem >= {1'b0, r_dsh};
    assign o_done = r_cnt == '0;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_num;
            r_dsh  <= i_dsh;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            if (ge) begin
                r_rem <= r_rem - {1'b0, r_dsh};
            end
            r_quot <= {r_quot[alstat_pkg::DIVQ_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
        end
    end
endmodule
`default_nettype wire

/* rtl/alstat_dp.sv */
// Datapath: channel stores, histogram memory, envelope math and percentile search.
`default_nettype none
module alstat_dp #(
    parameter int CHANNELS  = 8,
    parameter int HIST_BINS = 100
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire alstat_pkg::t_cmd                     i_cmd,
    output alstat_pkg::t_sts                          o_sts,
    input  wire logic                                 i_mode,
    input  wire logic [2:0]                           i_channel,
    input  wire logic signed [alstat_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                 i_cfg_we,
    input  wire logic [alstat_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [alstat_pkg::COEF_W-1:0]        i_cfg_wdata,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic [2:0]                                o_report_channel,
    output logic signed [alstat_pkg::SAMPLE_W-1:0]    o_min_sample,
    output logic signed [alstat_pkg::SAMPLE_W-1:0]    o_max_sample,
    output logic signed [alstat_pkg::SUM_W-1:0]       o_value_total,
    output logic [alstat_pkg::MSUM_W-1:0]             o_magnitude_total,
    output logic [alstat_pkg::MSUM_W-1:0]             o_square_total,
    output logic [alstat_pkg::ENV_W-1:0]              o_peak_envelope,
    output logic [alstat_pkg::CNT_W-1:0]              o_count_seen,
    output logic [alstat_pkg::SAMPLE_W-1:0]           o_percentile_magnitude
);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HBW   = $clog2(HIST_BINS);
    localparam int DEPTH = CHANNELS * HIST_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SCALE_SH = alstat_pkg::SCALE_W + $clog2(HIST_BINS);
    localparam int PROD_W   = alstat_pkg::SCALE_W + 32;
    // Rounded-up reciprocal of HIST_BINS; exact for every numerator below 2^SCALE_W.
    localparam logic [31:0] RECIP =
        32'(((64'd1 << SCALE_SH) + 64'(HIST_BINS) - 64'd1) / 64'(HIST_BINS));

    // Configuration.
    logic [alstat_pkg::COEF_W-1:0] r_attack;
    logic [alstat_pkg::FRAC_W-1:0] r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= alstat_pkg::ATTACK_RESET;
            r_frac   <= alstat_pkg::FRACTION_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                alstat_pkg::CFG_ATTACK:   r_attack <= i_cfg_wdata;
                alstat_pkg::CFG_FRACTION: r_frac <= i_cfg_wdata[alstat_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-channel stores.
    logic signed [alstat_pkg::SAMPLE_W-1:0] r_min [CHANNELS];
    logic signed [alstat_pkg::SAMPLE_W-1:0] r_max [CHANNELS];
    logic signed [alstat_pkg::SUM_W-1:0]    r_sum [CHANNELS];
    logic [alstat_pkg::MSUM_W-1:0]          r_abs [CHANNELS];
    logic [alstat_pkg::MSUM_W-1:0]          r_sqs [CHANNELS];
    logic [alstat_pkg::ENV_W-1:0]           r_env [CHANNELS];
    logic [alstat_pkg::ENV_W-1:0]           r_peak [CHANNELS];
    logic [alstat_pkg::CNT_W-1:0]           r_cnt [CHANNELS];

    // Histogram memory.
    logic [alstat_pkg::CNT_W-1:0] mem [DEPTH];
    logic [alstat_pkg::CNT_W-1:0] r_rd;
    logic [AW-1:0]                r_haddr;
    logic [AW-1:0]                r_clr;

    // Item registers.
    logic [CW-1:0]                          r_ch;
    logic signed [alstat_pkg::SAMPLE_W-1:0] r_s;
    logic [alstat_pkg::SAMPLE_W-1:0]        r_mag;
    logic [alstat_pkg::SQ_W-1:0]            r_sq;
    logic [57:0]                            r_p1;
    logic [56:0]                            r_p2;
    logic [alstat_pkg::TGT_W-1:0]           r_tgt;
    logic [alstat_pkg::PREFIX_W-1:0]        r_prefix;
    logic [HBW-1:0]                         r_idx;
    logic [alstat_pkg::SAMPLE_W-1:0]        r_pm;
    logic                                   r_out_valid;

    // Sample arithmetic.
    logic [alstat_pkg::SAMPLE_W-1:0] mag_c;
    logic [47:0]                     sq_full;
    logic [30:0]                     bin_full;
    logic [7:0]                      bin_raw;
    logic [HBW-1:0]                  bin_c;
    logic [AW-1:0]                   smp_addr;
    logic [AW-1:0]                   rep_addr;
    logic [AW-1:0]                   rd_addr;
    logic                            rd_en;
    logic [24:0]                     dcoef;
    logic [58:0]                     env_sum;
    logic [alstat_pkg::ENV_W-1:0]    env_new;
    logic signed [alstat_pkg::SUM_W-1:0] s64;
    logic signed [alstat_pkg::SUM_W-1:0] sum_add;
    logic signed [alstat_pkg::SUM_W-1:0] sum_new;
    logic                            sum_ovf;
    logic [63:0]                     abs_add;
    logic [63:0]                     sq_add;
    logic                            first;

    assign mag_c    = r_s[alstat_pkg::SAMPLE_W-1] ? (~r_s + 24'd1) : r_s;
    assign sq_full  = 48'(mag_c) * 48'(mag_c);
    assign bin_full = 31'(mag_c) * 31'(HIST_BINS);
    assign bin_raw  = bin_full[30:23];
    assign bin_c    = (32'(bin_raw) > HIST_BINS - 1) ? HBW'(HIST_BINS - 1) : HBW'(bin_raw);
    assign smp_addr = AW'(32'(r_ch) * HIST_BINS + 32'(bin_c));
    assign rep_addr = AW'(32'(r_ch) * HIST_BINS + 32'(r_idx));
    assign rd_addr  = i_cmd.smp_a ? smp_addr : rep_addr;
    assign rd_en    = i_cmd.smp_a | i_cmd.rep_read;

    assign dcoef   = 25'h1000000 - 25'(r_attack);
    assign env_sum = 59'(r_p1) + 59'(r_p2);
    assign env_new = env_sum[56:24];

    assign s64     = 64'(r_s);
    assign sum_add = r_sum[r_ch] + s64;
    assign sum_ovf = (r_sum[r_ch][63] == s64[63]) && (sum_add[63] != s64[63]);
    assign sum_new = sum_ovf ? (s64[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_add;
    assign abs_add = {1'b0, r_abs[r_ch]} + 64'(r_mag);
    assign sq_add  = {1'b0, r_sqs[r_ch]} + 64'(r_sq);
    assign first   = r_cnt[r_ch] == '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.smp_wb) begin
            mem[r_haddr] <= (r_rd == '1) ? r_rd : r_rd + 1'b1;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Input and sample pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch <= CW'(i_channel);
            r_s  <= i_sample;
        end
        if (i_cmd.smp_a) begin
            r_mag   <= mag_c;
            r_sq    <= sq_full[46:14];
            r_haddr <= smp_addr;
        end
        if (i_cmd.smp_b) begin
            r_p1 <= 58'(r_env[r_ch]) * 58'(dcoef);
            r_p2 <= 57'(r_sq) * 57'(r_attack);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_min[c]  <= '0;
                r_max[c]  <= '0;
                r_sum[c]  <= '0;
                r_abs[c]  <= '0;
                r_sqs[c]  <= '0;
                r_env[c]  <= '0;
                r_peak[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else if (i_cmd.smp_wb) begin
            if (first || r_s < r_min[r_ch]) begin
                r_min[r_ch] <= r_s;
            end
            if (first || r_s > r_max[r_ch]) begin
                r_max[r_ch] <= r_s;
            end
            r_sum[r_ch] <= sum_new;
            r_abs[r_ch] <= abs_add[63] ? '1 : abs_add[62:0];
            r_sqs[r_ch] <= sq_add[63] ? '1 : sq_add[62:0];
            if (r_cnt[r_ch] != '1) begin
                r_cnt[r_ch] <= r_cnt[r_ch] + 1'b1;
            end
            r_env[r_ch] <= env_new;
            if (env_new > r_peak[r_ch]) begin
                r_peak[r_ch] <= env_new;
            end
        end
    end

    // Percentile search over the prefix sums of the channel's bins.
    logic [alstat_pkg::PREFIX_W-1:0] pre_new;
    logic [62:0]                     pre_cmp;
    logic [62:0]                     tgt_cmp;
    logic [62:0]                     frac_diff;
    logic [22:0]                     scale_r;
    logic [alstat_pkg::SCALE_W-1:0]  scale_num;
    logic [alstat_pkg::SCALE_W-1:0]  r_num;
    logic [PROD_W-1:0]               scale_prod;
    logic                            div_load;
    logic [alstat_pkg::DIVN_W-1:0]   div_num;
    logic [alstat_pkg::DIVD_W-1:0]   div_dsh;
    logic [alstat_pkg::STEP_W-1:0]   div_steps;
    logic                            div_done;
    logic [alstat_pkg::DIVQ_W-1:0]   div_q;

    assign pre_new   = r_prefix + alstat_pkg::PREFIX_W'(r_rd);
    assign pre_cmp   = {pre_new, 16'd0};
    assign tgt_cmp   = 63'(r_tgt);
    assign frac_diff = tgt_cmp - {r_prefix, 16'd0};
    assign scale_r   = i_cmd.div_scale ? div_q : '0;
    assign scale_num = alstat_pkg::SCALE_W'({r_idx, 23'd0})
                     + alstat_pkg::SCALE_W'(scale_r);
    // The division by HIST_BINS is a multiplication by its reciprocal.
    assign scale_prod = PROD_W'(r_num) * PROD_W'(RECIP);
    assign div_load  = i_cmd.div_frac;
    assign div_num   = {frac_diff[55:0], 7'd0};
    assign div_dsh   = {r_rd, 22'd0};
    assign div_steps = alstat_pkg::DIV_FRAC_STEPS;

    alstat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_num   (div_num),
        .i_dsh   (div_dsh),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_init) begin
            r_tgt    <= 56'(r_cnt[r_ch]) * 56'(r_frac);
            r_prefix <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.rep_check) begin
                r_prefix <= pre_new;
            end
            if (i_cmd.rep_next) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.div_exact || i_cmd.div_scale) begin
            r_num <= scale_num;
        end
        if (i_cmd.mag_zero) begin
            r_pm <= '0;
        end else if (i_cmd.mag_take) begin
            r_pm <= scale_prod[SCALE_SH +: alstat_pkg::SAMPLE_W];
        end
    end

    // Output register with clamp of the percentile to the channel's range.
    logic signed [24:0] m25;
    logic signed [24:0] mx25;
    logic signed [24:0] mn25;
    logic signed [24:0] clamp;

    assign m25   = {1'b0, r_pm};
    assign mx25  = 25'(r_max[r_ch]);
    assign mn25  = 25'(r_min[r_ch]);
    assign clamp = (m25 > mx25) ? mx25 : ((m25 < mn25) ? mn25 : m25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_report_channel       <= 3'(r_ch);
            o_min_sample           <= r_min[r_ch];
            o_max_sample           <= r_max[r_ch];
            o_value_total          <= r_sum[r_ch];
            o_magnitude_total      <= r_abs[r_ch];
            o_square_total         <= r_sqs[r_ch];
            o_peak_envelope        <= r_peak[r_ch];
            o_count_seen           <= r_cnt[r_ch];
            o_percentile_magnitude <= clamp[24] ? '0 : clamp[23:0];
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.clr_last = r_clr == AW'(DEPTH - 1);
        o_sts.mode     = i_mode;
        o_sts.ch_ok    = 32'(i_channel) < CHANNELS;
        o_sts.hit_eq   = pre_cmp == tgt_cmp;
        o_sts.hit_gt   = pre_cmp > tgt_cmp;
        o_sts.last_bin = r_idx == HBW'(HIST_BINS - 1);
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end
endmodule
`default_nettype wire

/* rtl/alstat_ctrl.sv */
// Controller state machine: sequences clearing, sample updates and reports.
`default_nettype none
module alstat_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output alstat_pkg::t_cmd       o_cmd,
    input  wire alstat_pkg::t_sts  i_sts
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SMP_A, ST_SMP_B, ST_SMP_WB, ST_REP_INIT,
        ST_REP_READ, ST_REP_CHECK, ST_DIV_FRAC, ST_DIV_SCALE, ST_REP_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = r_state == ST_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && i_sts.ch_ok) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_sts.mode == alstat_pkg::MODE_REPORT) ? ST_REP_INIT
                                                                      : ST_SMP_A;
                end
            end
            ST_SMP_A: begin
                o_cmd.smp_a = 1'b1;
                n_state = ST_SMP_B;
            end
            ST_SMP_B: begin
                o_cmd.smp_b = 1'b1;
                n_state = ST_SMP_WB;
            end
            ST_SMP_WB: begin
                o_cmd.smp_wb = 1'b1;
                n_state = ST_IDLE;
            end
            ST_REP_INIT: begin
                o_cmd.rep_init = 1'b1;
                n_state = ST_REP_READ;
            end
            ST_REP_READ: begin
                o_cmd.rep_read = 1'b1;
                n_state = ST_REP_CHECK;
            end
            ST_REP_CHECK: begin
                o_cmd.rep_check = 1'b1;
                if (i_sts.hit_eq) begin
                    o_cmd.div_exact = 1'b1;
                    n_state = ST_DIV_SCALE;
                end else if (i_sts.hit_gt) begin
                    o_cmd.div_frac = 1'b1;
                    n_state = ST_DIV_FRAC;
                end else if (i_sts.last_bin) begin
                    o_cmd.mag_zero = 1'b1;
                    n_state = ST_REP_OUT;
                end else begin
                    o_cmd.rep_next = 1'b1;
                    n_state = ST_REP_READ;
                end
            end
            ST_DIV_FRAC: begin
                if (i_sts.div_done) begin
                    o_cmd.div_scale = 1'b1;
                    n_state = ST_DIV_SCALE;
                end
            end
            ST_DIV_SCALE: begin
                o_cmd.mag_take = 1'b1;
                n_state = ST_REP_OUT;
            end
            ST_REP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* rtl/audio_level_statistics_top.sv */
// Top level of the per-channel audio level statistics block.
//
//  Channel   Signals                                  Direction
//  input     i_in_valid/o_in_ready, mode/channel/sample   in
//  result    o_out_valid/i_out_ready, report fields       out
//  config    i_cfg_we, i_cfg_addr, i_cfg_wdata            in
//
// A sample transfer runs the accepting idle state, then ST_SMP_A, ST_SMP_B and
// ST_SMP_WB, in which the stores are written.
// A report runs ST_REP_INIT, then ST_REP_READ/ST_REP_CHECK per bin up to the bin b
// where the search stops, plus the bit-serial divider when the target falls in a bin.
// After reset a clearing pass writes CHANNELS*HIST_BINS histogram words, one a cycle,
// with o_in_ready low. A waiting result only stalls the next report's last step.
`default_nettype none
module audio_level_statistics_top #(
    parameter int CHANNELS  = 8,
    parameter int HIST_BINS = 100
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_mode,
    input  wire logic [2:0]                             i_channel,
    input  wire logic signed [alstat_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                   i_cfg_we,
    input  wire logic [alstat_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire logic [alstat_pkg::COEF_W-1:0]          i_cfg_wdata,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [2:0]                                  o_report_channel,
    output logic signed [alstat_pkg::SAMPLE_W-1:0]      o_min_sample,
    output logic signed [alstat_pkg::SAMPLE_W-1:0]      o_max_sample,
    output logic signed [alstat_pkg::SUM_W-1:0]         o_value_total,
    output logic [alstat_pkg::MSUM_W-1:0]               o_magnitude_total,
    output logic [alstat_pkg::MSUM_W-1:0]               o_square_total,
    output logic [alstat_pkg::ENV_W-1:0]                o_peak_envelope,
    output logic [alstat_pkg::CNT_W-1:0]                o_count_seen,
    output logic [alstat_pkg::SAMPLE_W-1:0]             o_percentile_magnitude
);
    alstat_pkg::t_cmd cmd;
    alstat_pkg::t_sts sts;

    alstat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    alstat_dp #(
        .CHANNELS  (CHANNELS),
        .HIST_BINS (HIST_BINS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_mode                 (i_mode),
        .i_channel              (i_channel),
        .i_sample               (i_sample),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_addr             (i_cfg_addr),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_out_ready            (i_out_ready),
        .o_out_valid            (o_out_valid),
        .o_report_channel       (o_report_channel),
        .o_min_sample           (o_min_sample),
        .o_max_sample           (o_max_sample),
        .o_value_total          (o_value_total),
        .o_magnitude_total      (o_magnitude_total),
        .o_square_total         (o_square_total),
        .o_peak_envelope        (o_peak_envelope),
        .o_count_seen           (o_count_seen),
        .o_percentile_magnitude (o_percentile_magnitude)
    );
endmodule
`default_nettype wire

/* tb/audio_level_statistics_top_test.sv */
// Self-checking testbench for the per-channel audio level statistics block.
`timescale 1ns / 1ps
`default_nettype none
module audio_level_statistics_top_test;

    localparam int NCH = 8;
    localparam int NBINS = 100;
    localparam int RANDOM_PER_PHASE = 530;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'h00FF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         ch;
        logic signed [23:0] min_s;
        logic signed [23:0] max_s;
        logic signed [63:0] total;
        logic [62:0]        mag_total;
        logic [62:0]        sq_total;
        logic [32:0]        peak;
        logic [39:0]        count;
        logic [23:0]        pct;
    } report_t;

    typedef struct packed {
        logic               mode;
        logic [2:0]         ch;
        logic signed [23:0] sample;
        logic               typed;
        report_t            want;
    } row_t;

    localparam report_t EMPTY_REPORT = '0;
    localparam report_t ONE_NEG_FULL = '{3'd1, -24'sd8388608, -24'sd8388608,
        -64'sd8388608, 63'd8388608, 63'd4294967296, 33'd4187904, 40'd1, 24'd0};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_mode = alstat_pkg::MODE_SAMPLE;
    logic [2:0] i_channel = '0;
    logic signed [23:0] i_sample = '0;
    logic i_cfg_we = 1'b0;
    logic [alstat_pkg::CFG_IDX_W-1:0] i_cfg_addr = alstat_pkg::CFG_ATTACK;
    logic [alstat_pkg::COEF_W-1:0] i_cfg_wdata = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    report_t got;

    audio_level_statistics_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_channel(i_channel), .i_sample(i_sample),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_report_channel(got.ch), .o_min_sample(got.min_s), .o_max_sample(got.max_s),
        .o_value_total(got.total), .o_magnitude_total(got.mag_total),
        .o_square_total(got.sq_total), .o_peak_envelope(got.peak),
        .o_count_seen(got.count), .o_percentile_magnitude(got.pct)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the channel statistics.
    logic [23:0] attack;
    logic [15:0] fraction;
    logic signed [23:0] ch_min [NCH];
    logic signed [23:0] ch_max [NCH];
    logic signed [63:0] ch_sum [NCH];
    logic [63:0] ch_abs [NCH];
    logic [63:0] ch_sq [NCH];
    logic [63:0] ch_env [NCH];
    logic [63:0] ch_peak [NCH];
    logic [63:0] ch_count [NCH];
    logic [63:0] ch_hist [NCH][NBINS];

    report_t pending_reports[$];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int mismatches = 0;
    longint cycles = 0;

    function automatic logic [63:0] sat_up(logic [63:0] acc, logic [63:0] add,
                                           logic [63:0] lim);
        if (add >= lim || acc > lim - add) return lim;
        return acc + add;
    endfunction

    task automatic accumulate_sample(int ch, logic signed [23:0] s);
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] bin;
        logic signed [64:0] wide;
        mag = (s < 0) ? 64'(-65'(s)) : 64'(s);
        sq = (mag * mag) >> 14;
        if (ch_count[ch] == 0) begin
            ch_min[ch] = s;
            ch_max[ch] = s;
        end
        if (s < ch_min[ch]) ch_min[ch] = s;
        if (s > ch_max[ch]) ch_max[ch] = s;
        wide = 65'(ch_sum[ch]) + 65'(s);
        if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) ch_sum[ch] = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (wide < -65'sh0_8000_0000_0000_0000) ch_sum[ch] = 64'sh8000_0000_0000_0000;
        else ch_sum[ch] = wide[63:0];
        ch_abs[ch] = sat_up(ch_abs[ch], mag, MAX63);
        ch_sq[ch] = sat_up(ch_sq[ch], sq, MAX63);
        ch_count[ch] = sat_up(ch_count[ch], 64'd1, MAX40);
        ch_env[ch] = (ch_env[ch] * ((64'd1 << 24) - 64'(attack)) + sq * 64'(attack)) >> 24;
        if (ch_env[ch] > ch_peak[ch]) ch_peak[ch] = ch_env[ch];
        bin = (mag * NBINS) >> 23;
        if (bin > NBINS - 1) bin = NBINS - 1;
        ch_hist[ch][bin] = sat_up(ch_hist[ch][bin], 64'd1, MAX40);
    endtask

    function automatic logic [23:0] percentile_of(int ch);
        logic [63:0] target;
        logic [63:0] prefix;
        logic [63:0] prev;
        logic [63:0] r;
        longint m;
        target = ch_count[ch] * 64'(fraction);
        prefix = 0;
        m = 0;
        for (int i = 0; i < NBINS; i++) begin
            prev = prefix;
            prefix = prefix + ch_hist[ch][i];
            if ((prefix << 16) == target) begin
                m = longint'((64'(i) << 23) / NBINS);
                break;
            end
            if ((prefix << 16) > target) begin
                r = ((target - (prev << 16)) << 7) / (prefix - prev);
                m = longint'(((64'(i) << 23) + r) / NBINS);
                break;
            end
        end
        if (m > longint'(ch_max[ch])) m = ch_max[ch];
        else if (m < longint'(ch_min[ch])) m = ch_min[ch];
        if (m < 0) m = 0;
        return m[23:0];
    endfunction

    function automatic report_t report_of(int ch);
        report_t rep;
        rep.ch = ch[2:0];
        rep.min_s = ch_min[ch];
        rep.max_s = ch_max[ch];
        rep.total = ch_sum[ch];
        rep.mag_total = ch_abs[ch][62:0];
        rep.sq_total = ch_sq[ch][62:0];
        rep.peak = ch_peak[ch][32:0];
        rep.count = ch_count[ch][39:0];
        rep.pct = percentile_of(ch);
        return rep;
    endfunction

    // One input transfer; the mirror is updated once it is accepted.
    task automatic send_item(logic mode, logic [2:0] ch, logic signed [23:0] s,
                             logic typed, report_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_channel <= ch;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode == alstat_pkg::MODE_REPORT)
            pending_reports.push_back(typed ? want : report_of(ch));
        else accumulate_sample(ch, s);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [alstat_pkg::CFG_IDX_W-1:0] idx, logic [23:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == alstat_pkg::CFG_ATTACK) attack = value;
        else fraction = value[15:0];
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        logic signed [23:0] s;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: s = -24'sd8388608;
                1: s = 24'sd8388607;
                2: s = 24'($signed($urandom_range(200)) - 100);
                default: s = 24'($urandom);
            endcase
            if ($urandom_range(99) < 12)
                send_item(alstat_pkg::MODE_REPORT, 3'($urandom_range(7)), s, 1'b0,
                          EMPTY_REPORT);
            else
                send_item(alstat_pkg::MODE_SAMPLE, 3'($urandom_range(7)), s, 1'b0,
                          EMPTY_REPORT);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        if (o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing expected: %p", got);
            end else begin
                report_t want;
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch:\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    row_t directed[] = '{
        '{alstat_pkg::MODE_REPORT, 3'd0, 24'sd0, 1'b1, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd1, -24'sd8388608, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd1, 24'sd0, 1'b1, ONE_NEG_FULL},
        '{alstat_pkg::MODE_SAMPLE, 3'd2, 24'sd8388607, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd2, 24'sd0, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd2, -24'sd1, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd2, 24'sd1, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd2, 24'sd0, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd3, 24'sd8388607, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd3, 24'sd8388607, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd3, 24'sd0, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd4, -24'sd1, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd4, -24'sd100, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd4, -24'sd4194304, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd4, 24'sd0, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd7, 24'sd4194304, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd7, 24'sd838860, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_SAMPLE, 3'd7, -24'sd838861, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd7, 24'sd0, 1'b0, EMPTY_REPORT},
        '{alstat_pkg::MODE_REPORT, 3'd5, 24'sd0, 1'b0, EMPTY_REPORT}
    };

    initial begin
        attack = alstat_pkg::ATTACK_RESET;
        fraction = alstat_pkg::FRACTION_RESET;
        for (int c = 0; c < NCH; c++) begin
            ch_min[c] = 0; ch_max[c] = 0; ch_sum[c] = 0; ch_abs[c] = 0; ch_sq[c] = 0;
            ch_env[c] = 0; ch_peak[c] = 0; ch_count[c] = 0;
            for (int b = 0; b < NBINS; b++) ch_hist[c][b] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_item(directed[k].mode, directed[k].ch, directed[k].sample,
                      directed[k].typed, directed[k].want);
        drain_results();

        write_reg(alstat_pkg::CFG_ATTACK, 24'd0);
        write_reg(alstat_pkg::CFG_FRACTION, 24'd0);
        tx_idle_pct = 37;
        rx_idle_pct = 59;
        random_phase(RANDOM_PER_PHASE);
        drain_results();

        write_reg(alstat_pkg::CFG_ATTACK, 24'hFFFFFF);
        write_reg(alstat_pkg::CFG_FRACTION, 24'h00FFFF);
        tx_idle_pct = 59;
        rx_idle_pct = 37;
        random_phase(RANDOM_PER_PHASE);
        drain_results();

        write_reg(alstat_pkg::CFG_ATTACK, 24'($urandom));
        write_reg(alstat_pkg::CFG_FRACTION, 24'($urandom_range(65535)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = 1'b1;
        random_phase(RANDOM_PER_PHASE);
        drain_results();

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/alstat_pkg.sv
rtl/alstat_div.sv
rtl/alstat_dp.sv
rtl/alstat_ctrl.sv
rtl/audio_level_statistics_top.sv
tb/audio_level_statistics_top_test.sv
